// ===== rtl/ledl_pkg.sv =====
package ledl_pkg;

   // Luma precision; field ports stay at their fixed width, upper bits ignored.
   localparam int LUMA_BITS = 10;

   localparam int LumaW      = 10;
   localparam int LumaEffW   = (LUMA_BITS < LumaW) ? LUMA_BITS : LumaW;
   localparam int PredW      = 10;
   localparam int ThrW       = 10;
   localparam int FactorW    = 8;
   localparam int StrengthW  = 9;
   localparam int CsrDataW   = 10;
   localparam int CsrIndexW  = 3;

   // scale (Q4.4) * threshold, then * (1.0 - strength) in Q0.8
   localparam int ProdW      = FactorW + ThrW;
   localparam int MulW       = StrengthW;
   localparam int LimW       = ProdW + MulW;
   localparam int FracW      = 12;
   localparam int ShiftW     = LumaEffW + FracW;
   localparam int CmpW       = (LimW > ShiftW) ? LimW : ShiftW;
   localparam int ThrCmpW    = (LumaEffW > ThrW) ? LumaEffW : ThrW;
   localparam int ContrastW  = LumaEffW + FactorW;
   localparam int StrengthOne = 256;

   // Reset values
   localparam int EdgeThrReset   = 102;
   localparam int FactorReset    = 32;
   localparam int PredThrReset   = 10;
   localparam int PredScaleReset = 32;
   localparam int StrengthReset  = 102;
   localparam int ProdReset      = PredScaleReset * EdgeThrReset;
   localparam int MulReset       = StrengthOne - StrengthReset;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_EDGE_THRESHOLD        = 3'd0,
      CSR_CONTRAST_FACTOR       = 3'd1,
      CSR_PREDICATION_ENABLE    = 3'd2,
      CSR_PREDICATION_THRESHOLD = 3'd3,
      CSR_PREDICATION_SCALE     = 3'd4,
      CSR_PREDICATION_STRENGTH  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ThrW-1:0]    edge_threshold;
      logic [FactorW-1:0] contrast_factor;
      logic               predication_enable;
      logic [PredW-1:0]   predication_threshold;
      logic [ProdW-1:0]   thr_prod;   // predication_scale * edge_threshold
      logic [MulW-1:0]    pe_mul;     // 256 - saturated strength
   } cfg_type;

endpackage

// ===== rtl/ledl_if.sv =====
interface ledl_req_if;
   logic                        valid;
   logic                        ready;
   logic [ledl_pkg::LumaW-1:0]  luma_center;
   logic [ledl_pkg::LumaW-1:0]  luma_left;
   logic [ledl_pkg::LumaW-1:0]  luma_top;
   logic [ledl_pkg::LumaW-1:0]  luma_right;
   logic [ledl_pkg::LumaW-1:0]  luma_bottom;
   logic [ledl_pkg::LumaW-1:0]  luma_left_far;
   logic [ledl_pkg::LumaW-1:0]  luma_top_far;
   logic [ledl_pkg::PredW-1:0]  pred_center;
   logic [ledl_pkg::PredW-1:0]  pred_left;
   logic [ledl_pkg::PredW-1:0]  pred_top;
   logic                        pred_valid;

   modport source (
      output valid, luma_center, luma_left, luma_top, luma_right, luma_bottom,
             luma_left_far, luma_top_far, pred_center, pred_left, pred_top,
             pred_valid,
      input  ready
   );

   modport sink (
      input  valid, luma_center, luma_left, luma_top, luma_right, luma_bottom,
             luma_left_far, luma_top_far, pred_center, pred_left, pred_top,
             pred_valid,
      output ready
   );
endinterface

interface ledl_rsp_if;
   logic valid;
   logic ready;
   logic edge_left;
   logic edge_top;

   modport source (
      output valid, edge_left, edge_top,
      input  ready
   );

   modport sink (
      input  valid, edge_left, edge_top,
      output ready
   );
endinterface

// ===== rtl/ledl_csr.sv =====
module ledl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ledl_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [ledl_pkg::CsrDataW-1:0]   csr_wdata,
   output ledl_pkg::cfg_type               cfg
);
   import ledl_pkg::*;

   logic [ThrW-1:0]      edge_threshold_ff,        edge_threshold_in;
   logic [FactorW-1:0]   contrast_factor_ff,       contrast_factor_in;
   logic                 predication_enable_ff,    predication_enable_in;
   logic [ThrW-1:0]      predication_threshold_ff, predication_threshold_in;
   logic [FactorW-1:0]   predication_scale_ff,     predication_scale_in;
   logic [StrengthW-1:0] predication_strength_ff,  predication_strength_in;
   logic [ProdW-1:0]     thr_prod_ff,              thr_prod_in;
   logic [MulW-1:0]      pe_mul_ff,                pe_mul_in;
   logic [StrengthW-1:0] strength_sat;

   always_comb begin
      edge_threshold_in        = edge_threshold_ff;
      contrast_factor_in       = contrast_factor_ff;
      predication_enable_in    = predication_enable_ff;
      predication_threshold_in = predication_threshold_ff;
      predication_scale_in     = predication_scale_ff;
      predication_strength_in  = predication_strength_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_EDGE_THRESHOLD: begin
               edge_threshold_in = csr_wdata[ThrW-1:0];
            end
            CSR_CONTRAST_FACTOR: begin
               contrast_factor_in = csr_wdata[FactorW-1:0];
            end
            CSR_PREDICATION_ENABLE: begin
               predication_enable_in = csr_wdata[0];
            end
            CSR_PREDICATION_THRESHOLD: begin
               predication_threshold_in = csr_wdata[ThrW-1:0];
            end
            CSR_PREDICATION_SCALE: begin
               predication_scale_in = csr_wdata[FactorW-1:0];
            end
            CSR_PREDICATION_STRENGTH: begin
               predication_strength_in = csr_wdata[StrengthW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Derived terms are registered from the raw registers and follow them in the next cycle.
   always_comb begin
      strength_sat = (predication_strength_ff > StrengthW'(StrengthOne)) ?
                     StrengthW'(StrengthOne) : predication_strength_ff;
      pe_mul_in    = MulW'(StrengthOne) - MulW'(strength_sat);
      thr_prod_in  = ProdW'(predication_scale_ff) * ProdW'(edge_threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_threshold_ff        <= ThrW'(EdgeThrReset);
         contrast_factor_ff       <= FactorW'(FactorReset);
         predication_enable_ff    <= 1'b0;
         predication_threshold_ff <= ThrW'(PredThrReset);
         predication_scale_ff     <= FactorW'(PredScaleReset);
         predication_strength_ff  <= StrengthW'(StrengthReset);
         thr_prod_ff              <= ProdW'(ProdReset);
         pe_mul_ff                <= MulW'(MulReset);
      end else begin
         edge_threshold_ff        <= edge_threshold_in;
         contrast_factor_ff       <= contrast_factor_in;
         predication_enable_ff    <= predication_enable_in;
         predication_threshold_ff <= predication_threshold_in;
         predication_scale_ff     <= predication_scale_in;
         predication_strength_ff  <= predication_strength_in;
         thr_prod_ff              <= thr_prod_in;
         pe_mul_ff                <= pe_mul_in;
      end
   end

   always_comb begin
      cfg.edge_threshold        = edge_threshold_ff;
      cfg.contrast_factor       = contrast_factor_ff;
      cfg.predication_enable    = predication_enable_ff;
      cfg.predication_threshold = predication_threshold_ff;
      cfg.thr_prod              = thr_prod_ff;
      cfg.pe_mul                = pe_mul_ff;
   end

endmodule

// ===== rtl/luma_edge_detect_lca_core.sv =====
// Luma edge detector with local contrast adaptation. Each transfer on req_bus
// carries one pixel neighborhood (center, left, top, right, bottom, left-left,
// top-top luma plus three optional predication samples); each transfer on
// rsp_bus returns the left and top edge flags for that pixel, in order. The
// block takes one neighborhood per clock while rsp_bus is not stalled and
// returns its flags through three register stages (differences,
// products/max, decision); the output stage doubles as the result buffer,
// and ready propagates back through the stages so a stall on rsp_bus holds
// everything without loss. The csr_ port writes the six control registers
// by index; derived products of the registers pass through one more
// register, which is covered since an item reaches the stage that uses them
// only after it is taken. Write registers only while no item is in flight.
module luma_edge_detect_lca_core (
   input  logic                            clock,
   input  logic                            reset,
   ledl_req_if.sink                        req_bus,
   ledl_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [ledl_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [ledl_pkg::CsrDataW-1:0]   csr_wdata
);
   import ledl_pkg::*;

   cfg_type cfg;

   ledl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its content moves on.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   assign adv3 = !v3_ff || rsp_bus.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_bus.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_bus.valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: absolute differences, predication edge tests.
   // ---------------------------------------------------------------------
   logic [LumaEffW-1:0] lc, ll, lt, lr, lb, lll, ltt;
   logic [LumaEffW-1:0] s1_dl_in, s1_dt_in, s1_dr_in, s1_db_in, s1_dll_in, s1_dtt_in;
   logic [LumaEffW-1:0] s1_dl_ff, s1_dt_ff, s1_dr_ff, s1_db_ff, s1_dll_ff, s1_dtt_ff;
   logic [PredW-1:0]    pdl, pdt;
   logic                s1_pel_in, s1_pet_in, s1_pred_in;
   logic                s1_pel_ff, s1_pet_ff, s1_pred_ff;

   always_comb begin
      lc  = req_bus.luma_center[LumaEffW-1:0];
      ll  = req_bus.luma_left[LumaEffW-1:0];
      lt  = req_bus.luma_top[LumaEffW-1:0];
      lr  = req_bus.luma_right[LumaEffW-1:0];
      lb  = req_bus.luma_bottom[LumaEffW-1:0];
      lll = req_bus.luma_left_far[LumaEffW-1:0];
      ltt = req_bus.luma_top_far[LumaEffW-1:0];

      s1_dl_in  = (lc >= ll) ? lc - ll : ll - lc;
      s1_dt_in  = (lc >= lt) ? lc - lt : lt - lc;
      s1_dr_in  = (lc >= lr) ? lc - lr : lr - lc;
      s1_db_in  = (lc >= lb) ? lc - lb : lb - lc;
      s1_dll_in = (ll >= lll) ? ll - lll : lll - ll;
      s1_dtt_in = (lt >= ltt) ? lt - ltt : ltt - lt;

      pdl = (req_bus.pred_center >= req_bus.pred_left) ?
            req_bus.pred_center - req_bus.pred_left :
            req_bus.pred_left - req_bus.pred_center;
      pdt = (req_bus.pred_center >= req_bus.pred_top) ?
            req_bus.pred_center - req_bus.pred_top :
            req_bus.pred_top - req_bus.pred_center;

      s1_pel_in  = pdl >= cfg.predication_threshold;
      s1_pet_in  = pdt >= cfg.predication_threshold;
      s1_pred_in = cfg.predication_enable && req_bus.pred_valid;
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_dl_ff   <= s1_dl_in;
         s1_dt_ff   <= s1_dt_in;
         s1_dr_ff   <= s1_dr_in;
         s1_db_ff   <= s1_db_in;
         s1_dll_ff  <= s1_dll_in;
         s1_dtt_ff  <= s1_dtt_in;
         s1_pel_ff  <= s1_pel_in;
         s1_pet_ff  <= s1_pet_in;
         s1_pred_ff <= s1_pred_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: neighborhood max, plain threshold test, threshold limits for
   // the predicated test, contrast products.
   // ---------------------------------------------------------------------
   logic [LumaEffW-1:0]  max_a, max_b, max_c, max_d, s2_mx_in, s2_mx_ff;
   logic [LimW-1:0]      lim_pe, lim_full;
   logic [LimW-1:0]      s2_lim_l_in, s2_lim_t_in, s2_lim_l_ff, s2_lim_t_ff;
   logic [ContrastW-1:0] s2_cf_dl_in, s2_cf_dt_in, s2_cf_dl_ff, s2_cf_dt_ff;
   logic                 s2_plain_l_in, s2_plain_t_in, s2_plain_l_ff, s2_plain_t_ff;
   logic [LumaEffW-1:0]  s2_dl_ff, s2_dt_ff;
   logic                 s2_pred_ff;

   always_comb begin
      max_a    = (s1_dl_ff > s1_dr_ff) ? s1_dl_ff : s1_dr_ff;
      max_b    = (max_a > s1_dll_ff) ? max_a : s1_dll_ff;
      max_c    = (s1_dt_ff > s1_db_ff) ? s1_dt_ff : s1_db_ff;
      max_d    = (max_c > s1_dtt_ff) ? max_c : s1_dtt_ff;
      s2_mx_in = (max_b > max_d) ? max_b : max_d;

      // plain: D >= threshold
      s2_plain_l_in = ThrCmpW'(s1_dl_ff) >= ThrCmpW'(cfg.edge_threshold);
      s2_plain_t_in = ThrCmpW'(s1_dt_ff) >= ThrCmpW'(cfg.edge_threshold);

      // predicated: scale * thr * (256 - s) on predicated edges, else * 256
      lim_pe      = LimW'(cfg.thr_prod) * LimW'(cfg.pe_mul);
      lim_full    = LimW'({cfg.thr_prod, 8'b0});
      s2_lim_l_in = s1_pel_ff ? lim_pe : lim_full;
      s2_lim_t_in = s1_pet_ff ? lim_pe : lim_full;

      s2_cf_dl_in = ContrastW'(cfg.contrast_factor) * ContrastW'(s1_dl_ff);
      s2_cf_dt_in = ContrastW'(cfg.contrast_factor) * ContrastW'(s1_dt_ff);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_mx_ff      <= s2_mx_in;
         s2_plain_l_ff <= s2_plain_l_in;
         s2_plain_t_ff <= s2_plain_t_in;
         s2_lim_l_ff   <= s2_lim_l_in;
         s2_lim_t_ff   <= s2_lim_t_in;
         s2_cf_dl_ff   <= s2_cf_dl_in;
         s2_cf_dt_ff   <= s2_cf_dt_in;
         s2_dl_ff      <= s1_dl_ff;
         s2_dt_ff      <= s1_dt_ff;
         s2_pred_ff    <= s1_pred_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: final decision, held as the output buffer.
   // ---------------------------------------------------------------------
   logic pflag_l, pflag_t, flag_l, flag_t, keep_l, keep_t;
   logic edge_left_in, edge_top_in, edge_left_ff, edge_top_ff;
   logic [ContrastW-1:0] mx16;

   always_comb begin
      // D * 4096 against the limit (Q4.4 * Q0.8 leaves 12 fraction bits)
      pflag_l = CmpW'({s2_dl_ff, FracW'(0)}) >= CmpW'(s2_lim_l_ff);
      pflag_t = CmpW'({s2_dt_ff, FracW'(0)}) >= CmpW'(s2_lim_t_ff);
      flag_l  = s2_pred_ff ? pflag_l : s2_plain_l_ff;
      flag_t  = s2_pred_ff ? pflag_t : s2_plain_t_ff;

      // contrast adaptation: drop the flag when max * 16 > factor * D
      mx16   = ContrastW'({s2_mx_ff, 4'b0});
      keep_l = !(mx16 > s2_cf_dl_ff);
      keep_t = !(mx16 > s2_cf_dt_ff);

      edge_left_in = flag_l && keep_l;
      edge_top_in  = flag_t && keep_t;
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         edge_left_ff <= edge_left_in;
         edge_top_ff  <= edge_top_in;
      end
   end

   assign rsp_bus.valid     = v3_ff;
   assign rsp_bus.edge_left = edge_left_ff;
   assign rsp_bus.edge_top  = edge_top_ff;

endmodule

// ===== verif/tb_luma_edge_detect_lca_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the luma edge detector core.
// One pixel neighborhood goes in per req transfer, one pair of edge flags comes
// back per rsp transfer, in order. A small scoreboard predicts the flags at the
// moment a neighborhood is taken and compares them with what comes out.
module tb_luma_edge_detect_lca_core;
   import ledl_pkg::*;

   localparam int TimeoutNs   = 2_000_000;   // hard limit, far above a clean run
   localparam int IdlePct     = 12;          // percent of cycles each side idles
   localparam int PipeLatency = 3;           // differences, products/max, decision
   localparam int ReportLimit = 40;          // lines printed before going quiet
   localparam int LumaMax     = (1 << LumaW) - 1;
   localparam int PhaseItems  = 95;
   localparam int NumPhases   = 10;
   localparam int SteadyPhase = 3;           // no idling on either side here

   // unused register indexes; writes there must be dropped
   localparam logic [CsrIndexW-1:0] CsrSpareLo = 3'd6;
   localparam logic [CsrIndexW-1:0] CsrSpareHi = 3'd7;

   typedef struct packed {
      logic [LumaW-1:0] luma_center;
      logic [LumaW-1:0] luma_left;
      logic [LumaW-1:0] luma_top;
      logic [LumaW-1:0] luma_right;
      logic [LumaW-1:0] luma_bottom;
      logic [LumaW-1:0] luma_left_far;
      logic [LumaW-1:0] luma_top_far;
      logic [PredW-1:0] pred_center;
      logic [PredW-1:0] pred_left;
      logic [PredW-1:0] pred_top;
      logic             pred_valid;
   } pixel_type;

   typedef struct packed {
      logic edge_left;
      logic edge_top;
   } flags_type;

   // Edge flag scoreboard: own copy of the control registers, predicts the
   // flags for every neighborhood taken and checks results in order.
   class edge_flag_scoreboard;
      logic [ThrW-1:0]      edge_threshold;
      logic [FactorW-1:0]   contrast_factor;
      logic                 predication_enable;
      logic [PredW-1:0]     predication_threshold;
      logic [FactorW-1:0]   predication_scale;
      logic [StrengthW-1:0] predication_strength;
      flags_type            pending_flags[$];
      int unsigned          mismatch_count;

      function new();
         edge_threshold        = ThrW'(EdgeThrReset);
         contrast_factor       = FactorW'(FactorReset);
         predication_enable    = 1'b0;
         predication_threshold = PredW'(PredThrReset);
         predication_scale     = FactorW'(PredScaleReset);
         predication_strength  = StrengthW'(StrengthReset);
         mismatch_count        = 0;
      endfunction

      function void set_reg(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] data);
         case (idx)
            CSR_EDGE_THRESHOLD:        edge_threshold        = data[ThrW-1:0];
            CSR_CONTRAST_FACTOR:       contrast_factor       = data[FactorW-1:0];
            CSR_PREDICATION_ENABLE:    predication_enable    = data[0];
            CSR_PREDICATION_THRESHOLD: predication_threshold = data[PredW-1:0];
            CSR_PREDICATION_SCALE:     predication_scale     = data[FactorW-1:0];
            CSR_PREDICATION_STRENGTH:  predication_strength  = data[StrengthW-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned absdiff(int unsigned a, int unsigned b);
         return (a >= b) ? a - b : b - a;
      endfunction

      // threshold test for one side; predicated form is scale*thr*(1-s*pe) in
      // exact integers (Q4.4 scale, Q0.8 strength -> 2^12 on the delta side)
      function bit side_is_edge(int unsigned d, bit predicated, bit pred_edge);
         int unsigned s;
         int unsigned lim;
         if (!predicated)
            return d >= edge_threshold;
         s   = (predication_strength > StrengthOne) ? StrengthOne : predication_strength;
         lim = predication_scale * edge_threshold * (pred_edge ? StrengthOne - s : StrengthOne);
         return d * 4096 >= lim;
      endfunction

      function flags_type compute_edge_flags(pixel_type p);
         int unsigned mask, c, l, t, r, b, ll, tt;
         int unsigned dl, dt, dr, db, dll, dtt, mx;
         bit          predicated, pel, pet;
         flags_type   f;
         mask = (1 << LumaEffW) - 1;
         c  = p.luma_center & mask;
         l  = p.luma_left & mask;
         t  = p.luma_top & mask;
         r  = p.luma_right & mask;
         b  = p.luma_bottom & mask;
         ll = p.luma_left_far & mask;
         tt = p.luma_top_far & mask;
         predicated = predication_enable && p.pred_valid;
         pel = absdiff(32'(p.pred_center), 32'(p.pred_left)) >= predication_threshold;
         pet = absdiff(32'(p.pred_center), 32'(p.pred_top)) >= predication_threshold;
         dl  = absdiff(c, l);
         dt  = absdiff(c, t);
         dr  = absdiff(c, r);
         db  = absdiff(c, b);
         dll = absdiff(l, ll);
         dtt = absdiff(t, tt);
         mx = dl;
         if (dt > mx) mx = dt;
         if (dr > mx) mx = dr;
         if (db > mx) mx = db;
         if (dll > mx) mx = dll;
         if (dtt > mx) mx = dtt;
         f.edge_left = side_is_edge(dl, predicated, pel);
         f.edge_top  = side_is_edge(dt, predicated, pet);
         // local contrast adaptation: drop a flag dwarfed by the biggest delta
         if (f.edge_left && mx * 16 > contrast_factor * dl) f.edge_left = 1'b0;
         if (f.edge_top && mx * 16 > contrast_factor * dt) f.edge_top = 1'b0;
         return f;
      endfunction

      function void note_pixel(pixel_type p);
         pending_flags.push_back(compute_edge_flags(p));
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= ReportLimit)
            $display("[%0t] flag check failed: %s", $time, what);
      endtask

      task check_flags(logic el, logic et);
         flags_type want;
         if (pending_flags.size() == 0) begin
            report_mismatch($sformatf("result with none pending (left=%b top=%b)", el, et));
            return;
         end
         want = pending_flags.pop_front();
         if (el !== want.edge_left)
            report_mismatch($sformatf("edge_left got %b want %b", el, want.edge_left));
         if (et !== want.edge_top)
            report_mismatch($sformatf("edge_top got %b want %b", et, want.edge_top));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CsrIndexW-1:0]  csr_index;
   logic [CsrDataW-1:0]   csr_wdata;
   bit                    steady_flow;
   edge_flag_scoreboard   sb;

   ledl_req_if req_bus();
   ledl_rsp_if rsp_bus();

   luma_edge_detect_lca_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case a transfer never completes
   initial begin
      #(TimeoutNs);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: check every rsp transfer, then pick next cycle's ready.
   // Values read here are the pre-edge ones, ready goes out by NBA.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_flags(rsp_bus.edge_left, rsp_bus.edge_top);
      rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IdlePct);
   end

   task automatic drive_payload(pixel_type p);
      req_bus.luma_center   <= p.luma_center;
      req_bus.luma_left     <= p.luma_left;
      req_bus.luma_top      <= p.luma_top;
      req_bus.luma_right    <= p.luma_right;
      req_bus.luma_bottom   <= p.luma_bottom;
      req_bus.luma_left_far <= p.luma_left_far;
      req_bus.luma_top_far  <= p.luma_top_far;
      req_bus.pred_center   <= p.pred_center;
      req_bus.pred_left     <= p.pred_left;
      req_bus.pred_top      <= p.pred_top;
      req_bus.pred_valid    <= p.pred_valid;
   endtask

   // Called at a clock edge. Random idle cycles first, then hold valid until
   // the transfer; valid is left high so back-to-back items never drop it.
   task automatic send_pixel(pixel_type p);
      while (!steady_flow && $urandom_range(99) < IdlePct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      drive_payload(p);
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_pixel(p);
   endtask

   // Stop sending, let every pending result come back plus pipeline slack.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending_flags.size() != 0) @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
   endtask

   // Upper data bits beyond the register width carry junk; the block must
   // ignore them. Leaves csr_wr_en high: callers lower it after the group.
   task automatic write_reg(logic [CsrIndexW-1:0] idx, int unsigned value, int width);
      int unsigned          mask;
      logic [CsrDataW-1:0]  data;
      mask = (1 << width) - 1;
      data = CsrDataW'(($urandom & ~mask) | (value & mask));
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   // Only called with the pipe empty. Ends with a write to an unused index,
   // which must not alias onto any real register.
   task automatic load_config(int unsigned thr, int unsigned factor, int unsigned en,
                              int unsigned pthr, int unsigned pscale, int unsigned pstr);
      write_reg(CSR_EDGE_THRESHOLD, thr, ThrW);
      write_reg(CSR_CONTRAST_FACTOR, factor, FactorW);
      write_reg(CSR_PREDICATION_ENABLE, en, 1);
      write_reg(CSR_PREDICATION_THRESHOLD, pthr, PredW);
      write_reg(CSR_PREDICATION_SCALE, pscale, FactorW);
      write_reg(CSR_PREDICATION_STRENGTH, pstr, StrengthW);
      write_reg($urandom_range(1) ? CsrSpareHi : CsrSpareLo, $urandom, 0);
      csr_wr_en <= 1'b0;
   endtask

   // mostly the ends of the range or the useful low part, sometimes anything
   function automatic int unsigned pick_value(int unsigned top, int unsigned useful);
      case ($urandom_range(5))
         0:       return 0;
         1:       return top;
         2, 3:    return $urandom_range(useful);
         default: return $urandom_range(top);
      endcase
   endfunction

   function automatic logic [LumaW-1:0] near(int base, int spread);
      int v;
      v = base - spread + int'($urandom_range(2 * spread));
      if (v < 0) v = 0;
      if (v > LumaMax) v = LumaMax;
      return v[LumaW-1:0];
   endfunction

   function automatic pixel_type build_pixel(int c, int l, int t, int r, int b, int ll,
                                             int tt, int pc, int pl, int pt, bit pv);
      pixel_type p;
      p.luma_center   = LumaW'(c);
      p.luma_left     = LumaW'(l);
      p.luma_top      = LumaW'(t);
      p.luma_right    = LumaW'(r);
      p.luma_bottom   = LumaW'(b);
      p.luma_left_far = LumaW'(ll);
      p.luma_top_far  = LumaW'(tt);
      p.pred_center   = PredW'(pc);
      p.pred_left     = PredW'(pl);
      p.pred_top      = PredW'(pt);
      p.pred_valid    = pv;
      return p;
   endfunction

   // Fully random neighborhoods almost always give huge deltas, so most items
   // are a smooth patch around one base level where thresholds and contrast
   // adaptation actually decide. Predication samples likewise sit close
   // together half the time to straddle the predication threshold.
   function automatic pixel_type random_pixel();
      bit [127:0] raw;
      pixel_type  p;
      int         base;
      int         spread;
      raw = {$urandom, $urandom, $urandom, $urandom};
      p   = raw[$bits(pixel_type)-1:0];
      if ($urandom_range(3) != 0) begin
         base = $urandom_range(LumaMax);
         case ($urandom_range(2))
            0:       spread = 8;
            1:       spread = 48;
            default: spread = 200;
         endcase
         p.luma_center   = near(base, spread);
         p.luma_left     = near(base, spread);
         p.luma_top      = near(base, spread);
         p.luma_right    = near(base, spread);
         p.luma_bottom   = near(base, spread);
         p.luma_left_far = near(int'(p.luma_left), spread);
         p.luma_top_far  = near(int'(p.luma_top), spread);
      end
      if ($urandom_range(1)) begin
         base   = $urandom_range(LumaMax);
         spread = $urandom_range(40);
         p.pred_center = near(base, spread);
         p.pred_left   = near(base, spread);
         p.pred_top    = near(base, spread);
      end
      return p;
   endfunction

   initial begin
      sb = new();
      steady_flow = 1'b0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      drive_payload('0);
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_EDGE_THRESHOLD;
      csr_wdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset settings (thr 102, factor 2.0, no predication) ---
      send_pixel(build_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(build_pixel(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1));
      send_pixel(build_pixel(1023, 0, 0, 0, 0, 0, 0, 1023, 0, 0, 1));
      send_pixel(build_pixel(0, 1023, 1023, 1023, 1023, 1023, 1023, 0, 1023, 1023, 0));
      send_pixel(build_pixel('h2AA, 'h155, 'h155, 'h2AA, 'h2AA, 'h2AA, 'h2AA,
                             'h155, 'h2AA, 'h155, 1));
      send_pixel(build_pixel('h155, 'h2AA, 'h2AA, 'h155, 'h155, 'h155, 'h155,
                             'h2AA, 'h155, 'h2AA, 0));
      // delta exactly at threshold on both sides
      send_pixel(build_pixel(102, 0, 0, 102, 102, 0, 0, 5, 5, 5, 0));
      // left edge kept, top below threshold
      send_pixel(build_pixel(600, 400, 550, 600, 600, 400, 550, 0, 0, 0, 0));
      // left edge cleared by a much stronger right-hand delta
      send_pixel(build_pixel(500, 380, 500, 900, 500, 380, 500, 0, 0, 0, 0));
      wait_drained();

      // --- zero threshold, zero contrast factor ---
      load_config(0, 0, 0, PredThrReset, PredScaleReset, StrengthReset);
      send_pixel(build_pixel(300, 300, 300, 300, 300, 300, 300, 0, 0, 0, 0));
      send_pixel(build_pixel(300, 301, 300, 300, 300, 301, 300, 0, 0, 0, 0));
      wait_drained();

      // --- predication on, scale 1.0, strength above one (saturates) ---
      load_config(500, 255, 1, 10, 16, 300);
      send_pixel(build_pixel(100, 100, 100, 100, 100, 100, 100, 0, 100, 100, 1));
      // same but no predication samples: plain threshold
      send_pixel(build_pixel(100, 100, 100, 100, 100, 100, 100, 0, 100, 100, 0));
      // no predicated edge, delta lands exactly on the scaled threshold
      send_pixel(build_pixel(600, 100, 600, 600, 600, 100, 600, 50, 50, 50, 1));
      // predicated edge on the left side only
      send_pixel(build_pixel(300, 250, 250, 300, 300, 250, 250, 0, 40, 5, 1));
      wait_drained();

      // --- every register at its top but strength, which is zero ---
      load_config(1023, 255, 1, 1023, 255, 0);
      send_pixel(build_pixel(1023, 0, 1023, 1023, 1023, 0, 1023, 1023, 0, 0, 1));
      send_pixel(build_pixel(1023, 0, 1023, 1023, 1023, 0, 1023, 1023, 0, 0, 0));
      wait_drained();

      // --- zero predication threshold, strength exactly one ---
      load_config(200, 32, 1, 0, 32, 256);
      send_pixel(build_pixel(400, 390, 420, 400, 400, 390, 420, 0, 0, 0, 1));
      send_pixel(build_pixel(0, 0, 1, 0, 0, 0, 1, 7, 7, 7, 1));
      wait_drained();

      // --- random: new settings each phase, one phase with no idling ---
      for (int ph = 0; ph < NumPhases; ph++) begin
         load_config(pick_value(1023, 160), pick_value(255, 64), $urandom_range(1),
                     pick_value(1023, 64), pick_value(255, 48), pick_value(511, 300));
         steady_flow = (ph == SteadyPhase);
         for (int i = 0; i < PhaseItems; i++)
            send_pixel(random_pixel());
         wait_drained();
         steady_flow = 1'b0;
      end

      if (sb.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
